/* hw/rtl/assert_macros.svh */
// Assertion macros used by the frame manager controller (pfm_ctrl).
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/pfm_pkg.sv */
// Package for the page frame manager: constants, codes, item and command/status structs.
// No dependencies.
package pfm_pkg;
  localparam int unsigned SlotsDef    = 16;
  localparam int unsigned PageIdDef   = 32;
  localparam int unsigned PinDef      = 8;
  localparam int unsigned CfgBits     = 5;
  localparam int unsigned SlotOutBits = 4;
  localparam int unsigned WbOutBits   = 32;

  localparam logic [CfgBits-1:0] CfgRst = 5'd16;

  localparam logic [1:0] CmdPin      = 2'd0;
  localparam logic [1:0] CmdUnpin    = 2'd1;
  localparam logic [1:0] CmdFlush    = 2'd2;
  localparam logic [1:0] CmdFlushAll = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoVictim = 3'd1;
  localparam logic [2:0] StNotRes   = 3'd2;
  localparam logic [2:0] StBadId    = 3'd3;
  localparam logic [2:0] StUnder    = 3'd4;
  localparam logic [2:0] StSat      = 3'd5;

  localparam logic [1:0] FillNone = 2'd0;
  localparam logic [1:0] FillZero = 2'd1;
  localparam logic [1:0] FillDisk = 2'd2;

  // result forms, picked by the controller, assembled in the top
  localparam logic [2:0] RkErr    = 3'd0;  // status only
  localparam logic [2:0] RkHit    = 3'd1;  // slot + hit (pin hit, unpin)
  localparam logic [2:0] RkInst   = 3'd2;  // sweep install
  localparam logic [2:0] RkFl     = 3'd3;  // flush of a found page
  localparam logic [2:0] RkAllWb  = 3'd4;  // flush-all write-back
  localparam logic [2:0] RkAllEnd = 3'd5;  // flush-all closing item

  localparam logic [0:0] AddrSlotsInUse = 1'b0;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] page_id;
    logic        zero_fill;
    logic        mark_dirty;
  } pfm_req_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        hit;
    logic        evicted;
    logic        writeback;
    logic [31:0] writeback_page;
    logic [1:0]  fill_mode;
    logic [2:0]  status;
    logic        last;
  } pfm_res_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch the input item, index := 0
    logic idx_inc;  // index := index + 1
    logic hand_fix; // hand := 0 if out of range, index := hand, clear step count
    logic hand_adv; // index/hand advance modulo n, count sweep step
    logic clr_use;  // clear usage at index
    logic do_hit;   // pin hit: bump pin, set usage
    logic do_inst;  // install new page at index
    logic do_unpin; // drop pin, maybe set dirty
    logic clr_dirty;// clear dirty at index
  } pfm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cmd_all;
    logic cmd_pin;
    logic cmd_unpin;
    logic id_zero;
    logic match;     // slot at index holds the page
    logic last_idx;  // index is n-1
    logic pinned;
    logic free;
    logic used;
    logic dirty;
    logic pin_max;
    logic sweep_done;// 2n sweep steps done
  } pfm_sts_t;
endpackage

/* hw/rtl/pfm_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface pfm_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/pfm_dp.sv */
// Datapath: slot table, scan index, sweep hand, latched item.
// Depends on pfm_pkg.
module pfm_dp #(
  parameter int unsigned SLOTS = pfm_pkg::SlotsDef,
  parameter int unsigned PAGE_ID_BITS = pfm_pkg::PageIdDef,
  parameter int unsigned PIN_BITS = pfm_pkg::PinDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [pfm_pkg::CfgBits-1:0] n_i,
  input  logic [1:0] command_i,
  input  logic [31:0] page_id_i,
  input  logic fresh_i,
  input  logic mark_dirty_i,
  input  pfm_pkg::pfm_cmd_t cmd_i,
  output pfm_pkg::pfm_sts_t sts_o,
  output logic [$clog2(SLOTS)-1:0] idx_o,
  output logic [PAGE_ID_BITS-1:0] res_page_o,
  output logic fresh_o
);
  import pfm_pkg::*;
  localparam int unsigned IB = $clog2(SLOTS);
  localparam int unsigned NB = IB + 1;
  localparam int unsigned CB = $clog2(2*SLOTS+1);

  logic [PAGE_ID_BITS-1:0] page_q [SLOTS];
  logic [PIN_BITS-1:0] pin_q [SLOTS];
  logic [SLOTS-1:0] use_q, dirty_q;
  logic [IB-1:0] idx_q, hand_q, nm1, idx_nxt;
  logic [CB-1:0] cnt_q;
  logic [1:0] cmdr_q;
  logic [PAGE_ID_BITS-1:0] id_q;
  logic fresh_q, md_q;
  logic [NB-1:0] n_eff;

  // clamp register to 1..SLOTS
  always_comb begin
    if (n_i == '0) n_eff = NB'(1);
    else if (32'(n_i) > SLOTS) n_eff = NB'(SLOTS);
    else n_eff = NB'(n_i);
  end
  assign nm1 = IB'(n_eff - 1'b1);
  assign idx_nxt = (idx_q == nm1) ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; hand_q <= '0; cnt_q <= '0;
      use_q <= '0; dirty_q <= '0;
      cmdr_q <= CmdPin; id_q <= '0; fresh_q <= 1'b0; md_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        page_q[i] <= '0; pin_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        cmdr_q <= command_i;
        id_q <= PAGE_ID_BITS'(page_id_i);
        fresh_q <= fresh_i; md_q <= mark_dirty_i;
      end
      // scan index
      if (cmd_i.load) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
      else if (cmd_i.hand_fix) idx_q <= (hand_q > nm1) ? '0 : hand_q;
      else if (cmd_i.hand_adv) idx_q <= idx_nxt;
      // sweep hand and step count
      if (cmd_i.hand_fix) begin
        cnt_q <= '0;
        if (hand_q > nm1) hand_q <= '0;
      end else if (cmd_i.hand_adv) begin
        cnt_q <= cnt_q + 1'b1;
        hand_q <= idx_nxt;
      end
      // slot table, one update per cycle
      if (cmd_i.do_hit) begin
        pin_q[idx_q] <= pin_q[idx_q] + 1'b1; use_q[idx_q] <= 1'b1;
      end else if (cmd_i.do_inst) begin
        page_q[idx_q] <= id_q; pin_q[idx_q] <= PIN_BITS'(1);
        use_q[idx_q] <= 1'b1; dirty_q[idx_q] <= 1'b0;
      end else if (cmd_i.do_unpin) begin
        pin_q[idx_q] <= pin_q[idx_q] - 1'b1;
        if (md_q) dirty_q[idx_q] <= 1'b1;
      end else if (cmd_i.clr_use) begin
        use_q[idx_q] <= 1'b0;
      end else if (cmd_i.clr_dirty) begin
        dirty_q[idx_q] <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.cmd_all   = (cmdr_q == CmdFlushAll);
    sts_o.cmd_pin   = (cmdr_q == CmdPin);
    sts_o.cmd_unpin = (cmdr_q == CmdUnpin);
    sts_o.id_zero   = (id_q == '0);
    sts_o.match     = (page_q[idx_q] == id_q);
    sts_o.last_idx  = (idx_q == nm1);
    sts_o.pinned    = (pin_q[idx_q] != '0);
    sts_o.free      = (page_q[idx_q] == '0);
    sts_o.used      = use_q[idx_q];
    sts_o.dirty     = dirty_q[idx_q];
    sts_o.pin_max   = (pin_q[idx_q] == '1);
    sts_o.sweep_done = (cnt_q == CB'({n_eff, 1'b0}));
  end
  assign idx_o = idx_q;
  assign res_page_o = page_q[idx_q];
  assign fresh_o = fresh_q;
endmodule

/* hw/rtl/pfm_ctrl.sv */
// Controller FSM: sequences lookup, clock sweep and flush-all, forms results.
// Depends on pfm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pfm_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output logic [2:0] kind_o,   // result form, see Rk*
  output logic [2:0] st_o,
  input  pfm_pkg::pfm_sts_t sts_i,
  output pfm_pkg::pfm_cmd_t cmd_o
);
  import pfm_pkg::*;
  typedef enum logic [4:0] {
    SIdle = 5'b00001, SLook = 5'b00010, SSwp = 5'b00100,
    SAll  = 5'b01000, SOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] kind_q, kind_d;
  logic [2:0] st_q, st_d;

  always_comb begin
    state_d = state_q; kind_d = kind_q; st_d = st_q;
    cmd_o = '0;
    unique case (state_q)
      SIdle: if (in_valid_i) begin cmd_o.load = 1'b1; state_d = SLook; end
      SLook: begin
        st_d = StOk; state_d = SOut;
        priority if (sts_i.cmd_all) state_d = SAll;
        else if (sts_i.id_zero) begin
          kind_d = RkErr; st_d = StBadId;
        end else if (sts_i.match) begin
          priority if (sts_i.cmd_pin) begin
            kind_d = RkHit;
            if (sts_i.pin_max) st_d = StSat;
          end else if (sts_i.cmd_unpin) begin
            kind_d = RkHit;
            if (!sts_i.pinned) st_d = StUnder;
          end else kind_d = RkFl;
        end else if (!sts_i.last_idx) begin
          cmd_o.idx_inc = 1'b1; state_d = SLook;
        end else if (sts_i.cmd_pin) begin
          cmd_o.hand_fix = 1'b1; state_d = SSwp;
        end else begin
          kind_d = RkErr; st_d = StNotRes;
        end
      end
      SSwp: begin
        priority if (sts_i.sweep_done) begin
          kind_d = RkErr; st_d = StNoVictim; state_d = SOut;
        end else if (!sts_i.pinned && (sts_i.free || !sts_i.used)) begin
          kind_d = RkInst; st_d = StOk; state_d = SOut;
        end else begin
          // pinned, or unpinned with usage set: skip it; an unpinned one loses its usage (second chance)
          cmd_o.clr_use = !sts_i.pinned;
          cmd_o.hand_adv = 1'b1;
        end
      end
      SAll: begin
        st_d = StOk;
        if (!sts_i.free && sts_i.dirty) begin
          kind_d = RkAllWb; state_d = SOut;
        end else if (sts_i.last_idx) begin
          kind_d = RkAllEnd; state_d = SOut;
        end else cmd_o.idx_inc = 1'b1;
      end
      SOut: if (out_ready_i) begin
        // table updates happen on delivery so the item stays stable while it waits
        state_d = SIdle;
        unique case (kind_q)
          RkHit: if (st_q == StOk) begin
            cmd_o.do_hit = sts_i.cmd_pin;
            cmd_o.do_unpin = sts_i.cmd_unpin;
          end
          RkInst: begin cmd_o.do_inst = 1'b1; cmd_o.hand_adv = 1'b1; end
          RkFl: cmd_o.clr_dirty = 1'b1;
          RkAllWb: begin
            cmd_o.clr_dirty = 1'b1;
            if (sts_i.last_idx) begin
              kind_d = RkAllEnd; state_d = SOut;
            end else begin cmd_o.idx_inc = 1'b1; state_d = SAll; end
          end
          default: ;
        endcase
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; kind_q <= RkErr; st_q <= StOk;
    end else begin
      state_q <= state_d; kind_q <= kind_d; st_q <= st_d;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign kind_o      = kind_q;
  assign st_o        = st_q;

  `ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `ASSERT_IMP(a_oneupd, clk_i, rst_ni, cmd_o.do_inst, state_q == SOut && kind_q == RkInst)
  `ASSERT_NXT(a_acc, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == SLook)
  `ASSERT_IMP(a_fix, clk_i, rst_ni, cmd_o.hand_fix, state_q == SLook)
endmodule

/* hw/rtl/page_frame_manager_clock_sweep_top.sv */
// Top level of the page frame manager: channels, APB register, ctrl + datapath.
// Depends on pfm_pkg, pfm_if, pfm_ctrl, pfm_dp.
// One item is in flight at a time; the single-ported slot table read at the
// scan index sets the pace. After an item is accepted the lookup examines the
// slots in order from slot 0, stopping at the first match (up to n, the clamped
// slots_in_use). A pin that misses then sweeps from the hand, giving up after
// 2n steps. Each result is held until the receiver is ready, and the block
// returns to idle before it accepts the next item. Flush-all examines every slot
// below n and delivers one result per dirty resident slot (its write-back),
// then a closing item. slots_in_use is written over APB at address 0; the user
// must write it only while idle, which the block itself does not enforce.
module page_frame_manager_clock_sweep_top #(
  parameter int unsigned SLOTS = pfm_pkg::SlotsDef,
  parameter int unsigned PAGE_ID_BITS = pfm_pkg::PageIdDef,
  parameter int unsigned PIN_BITS = pfm_pkg::PinDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  pfm_if.sink   in_if,
  pfm_if.source out_if,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [0:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import pfm_pkg::*;

  pfm_cmd_t cmd;
  pfm_sts_t sts;
  logic [CfgBits-1:0] n_q;
  logic [2:0] kind;
  logic [2:0] st;
  logic [$clog2(SLOTS)-1:0] idx;
  logic [PAGE_ID_BITS-1:0] rpage;
  logic fresh;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n_q <= CfgRst;
    else if (psel && penable && pwrite && pready && paddr == AddrSlotsInUse)
      n_q <= pwdata[CfgBits-1:0];
  end
  assign prdata = (paddr == AddrSlotsInUse) ? {27'd0, n_q} : 32'd0;

  pfm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_ready_i(out_if.ready), .out_valid_o(out_if.valid),
    .kind_o(kind), .st_o(st), .sts_i(sts), .cmd_o(cmd)
  );

  pfm_dp #(.SLOTS(SLOTS), .PAGE_ID_BITS(PAGE_ID_BITS), .PIN_BITS(PIN_BITS)) u_dp (
    .clk_i, .rst_ni, .n_i(n_q),
    .command_i(in_if.data.command), .page_id_i(in_if.data.page_id),
    .fresh_i(in_if.data.zero_fill), .mark_dirty_i(in_if.data.mark_dirty),
    .cmd_i(cmd), .sts_o(sts), .idx_o(idx), .res_page_o(rpage), .fresh_o(fresh)
  );

  // result item: fields come from the slot at the scan index
  always_comb begin
    out_if.data = '0;
    out_if.data.status = st;
    out_if.data.last = (kind != RkAllWb);
    unique case (kind)
      RkHit: begin out_if.data.slot = SlotOutBits'(idx); out_if.data.hit = 1'b1; end
      RkInst: begin
        out_if.data.slot = SlotOutBits'(idx);
        out_if.data.evicted = !sts.free;
        out_if.data.writeback = !sts.free && sts.dirty;
        out_if.data.writeback_page = (!sts.free && sts.dirty) ? WbOutBits'(rpage) : '0;
        out_if.data.fill_mode = fresh ? FillZero : FillDisk;
      end
      RkFl: begin
        out_if.data.slot = SlotOutBits'(idx); out_if.data.hit = 1'b1;
        if (sts.dirty) begin
          out_if.data.writeback = 1'b1;
          out_if.data.writeback_page = WbOutBits'(rpage);
        end
      end
      RkAllWb: begin
        out_if.data.slot = SlotOutBits'(idx); out_if.data.hit = 1'b1;
        out_if.data.writeback = 1'b1;
        out_if.data.writeback_page = WbOutBits'(rpage);
      end
      default: ;
    endcase
  end
endmodule

/* dv/pfm_tb_pkg.sv */
`timescale 1ns / 100ps
// Testbench constants for the frame manager's predictor.
// Depends on pfm_pkg for widths.
package pfm_tb_pkg;
  import pfm_pkg::*;

  localparam int unsigned PinMax = (1 << PinDef) - 1;
endpackage

/* dv/pfm_checker.sv */
`timescale 1ns / 100ps
// Frame table predictor and result scoreboard for the page frame manager.
// Depends on pfm_pkg and pfm_tb_pkg; watches the channels and the APB port.
module pfm_checker
  import pfm_pkg::*;
  import pfm_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  pfm_req_t    req_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  pfm_res_t    res_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [0:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  input  logic        drain_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);
  logic [31:0] frame_page [SlotsDef];
  logic [7:0]  pin_cnt [SlotsDef];
  bit          use_bit [SlotsDef];
  bit          dirty_bit [SlotsDef];
  int          hand;
  logic [4:0]  slots_cfg;
  pfm_res_t    expected_q [$];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  function automatic void push_res(int s, bit h, bit ev, bit wb, logic [31:0] wbp,
                                   logic [1:0] fill, logic [2:0] st, bit lst);
    pfm_res_t r;
    r.slot = s[3:0]; r.hit = h; r.evicted = ev; r.writeback = wb;
    r.writeback_page = wbp; r.fill_mode = fill; r.status = st; r.last = lst;
    expected_q.push_back(r);
  endfunction

  // clock sweep over the first n slots; -1 when every slot is pinned
  function automatic int sweep_pick(int n);
    int idx;
    if (hand >= n) hand = 0;
    for (int k = 0; k < 2 * n; k++) begin
      idx = hand;
      hand = (idx + 1 >= n) ? 0 : idx + 1;
      if (pin_cnt[idx] != 0) continue;
      if (frame_page[idx] == 0) return idx;
      if (use_bit[idx]) begin
        use_bit[idx] = 0;
        continue;
      end
      return idx;
    end
    return -1;
  endfunction

  function automatic void predict_frames(pfm_req_t r);
    int n, s;
    bit ev, wb;
    logic [31:0] wbp;
    n = (slots_cfg == 0) ? 1 : (slots_cfg > SlotsDef) ? SlotsDef : int'(slots_cfg);
    s = -1;
    if (r.command == CmdFlushAll) begin
      for (int i = 0; i < n; i++)
        if (frame_page[i] != 0 && dirty_bit[i]) begin
          push_res(i, 1, 0, 1, frame_page[i], FillNone, StOk, 0);
          dirty_bit[i] = 0;
        end
      push_res(0, 0, 0, 0, 0, FillNone, StOk, 1);
      return;
    end
    if (r.page_id == 0) begin
      push_res(0, 0, 0, 0, 0, FillNone, StBadId, 1);
      return;
    end
    for (int i = n - 1; i >= 0; i--)
      if (frame_page[i] == r.page_id) s = i;
    if (r.command == CmdPin) begin
      if (s >= 0) begin
        if (pin_cnt[s] >= PinMax) push_res(s, 1, 0, 0, 0, FillNone, StSat, 1);
        else begin
          pin_cnt[s]++;
          use_bit[s] = 1;
          push_res(s, 1, 0, 0, 0, FillNone, StOk, 1);
        end
        return;
      end
      s = sweep_pick(n);
      if (s < 0) begin
        push_res(0, 0, 0, 0, 0, FillNone, StNoVictim, 1);
        return;
      end
      ev = frame_page[s] != 0;
      wb = ev && dirty_bit[s];
      wbp = wb ? frame_page[s] : 32'h0;
      frame_page[s] = r.page_id;
      pin_cnt[s] = 1;
      use_bit[s] = 1;
      dirty_bit[s] = 0;
      push_res(s, 0, ev, wb, wbp, r.zero_fill ? FillZero : FillDisk, StOk, 1);
      return;
    end
    if (s < 0) begin
      push_res(0, 0, 0, 0, 0, FillNone, StNotRes, 1);
      return;
    end
    if (r.command == CmdUnpin) begin
      if (pin_cnt[s] == 0) push_res(s, 1, 0, 0, 0, FillNone, StUnder, 1);
      else begin
        pin_cnt[s]--;
        if (r.mark_dirty) dirty_bit[s] = 1;
        push_res(s, 1, 0, 0, 0, FillNone, StOk, 1);
      end
      return;
    end
    if (dirty_bit[s]) begin
      dirty_bit[s] = 0;
      push_res(s, 1, 0, 1, frame_page[s], FillNone, StOk, 1);
    end else push_res(s, 1, 0, 0, 0, FillNone, StOk, 1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pfm_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SlotsDef; i++) begin
        frame_page[i] = 0; pin_cnt[i] = 0; use_bit[i] = 0; dirty_bit[i] = 0;
      end
      hand = 0;
      slots_cfg = 5'd16;
      expected_q.delete();
      errors_o = 0;
      results_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == AddrSlotsInUse)
        slots_cfg = pwdata_i[4:0];
      if (res_valid_i && res_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) report("unexpected result", res_i.slot, 0);
        else begin
          want = expected_q.pop_front();
          if (res_i.slot !== want.slot) report("slot", res_i.slot, want.slot);
          if (res_i.hit !== want.hit) report("hit", res_i.hit, want.hit);
          if (res_i.evicted !== want.evicted) report("evicted", res_i.evicted, want.evicted);
          if (res_i.writeback !== want.writeback)
            report("writeback", res_i.writeback, want.writeback);
          if (res_i.writeback_page !== want.writeback_page)
            report("writeback_page", res_i.writeback_page, want.writeback_page);
          if (res_i.fill_mode !== want.fill_mode)
            report("fill_mode", res_i.fill_mode, want.fill_mode);
          if (res_i.status !== want.status) report("status", res_i.status, want.status);
          if (res_i.last !== want.last) report("last", res_i.last, want.last);
        end
      end
      if (req_valid_i && req_ready_i) predict_frames(req_i);
    end
    pending_o = expected_q.size();
  end

  always @(posedge drain_i)
    if (expected_q.size() != 0) report("results never delivered", expected_q.size(), 0);
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the page frame manager testbench: clock, reset, stimulus, verdict.
// Depends on pfm_pkg, pfm_tb_pkg, pfm_if, pfm_checker and the block itself.
module tb_top;
  import pfm_pkg::*;
  import pfm_tb_pkg::*;

  localparam int CycleLimit = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0] paddr = AddrSlotsInUse;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic pready;
  logic drain = 1'b0;

  pfm_if #(.T(pfm_req_t)) req_if ();
  pfm_if #(.T(pfm_res_t)) res_if ();

  int errors, pending, results;
  int items_sent = 0;
  int cycles = 0;
  int hold_left = 0;    // receiver hold-off, counted down by the receiver process
  bit calm = 1'b0;      // no idling on either side while set
  logic [31:0] id_pool [24];
  logic [31:0] pinned_q [$];  // pages we believe are pinned, steers unpins

  page_frame_manager_clock_sweep_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(req_if), .out_if(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pfm_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_if.valid), .req_ready_i(req_if.ready), .req_i(req_if.data),
    .res_valid_i(res_if.valid), .res_ready_i(res_if.ready), .res_i(res_if.data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .drain_i(drain),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result receiver: random stalls plus the long hold-off when requested
  initial begin
    int stall;
    stall = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        res_if.ready = 1'b0;
        stall--;
      end else begin
        res_if.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  // inputs change on the falling edge; blocking writes so a valid held
  // across back-to-back items is never dropped and raised in one step
  task automatic send_req(logic [1:0] cmd, logic [31:0] id, bit fresh, bit dirty);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk_i);
    req_if.data = '{command: cmd, page_id: id, zero_fill: fresh, mark_dirty: dirty};
    req_if.valid = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  // register writes only while nothing is in flight
  task automatic set_slots(int n);
    wait (pending == 0);
    repeat (60) @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = AddrSlotsInUse; pwdata = n;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    pinned_q.delete();
  endtask

  task automatic random_phase(int count, int n_eff);
    int r, k;
    logic [31:0] id;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      id = id_pool[$urandom_range(0, 23)];
      if (r < 3) send_req(CmdPin, 32'h0, $urandom_range(0, 1), $urandom_range(0, 1));
      else if (r < 8) send_req(CmdFlushAll, $urandom, $urandom_range(0, 1),
                               $urandom_range(0, 1));
      else if (r < 18) send_req(CmdFlush, id, $urandom_range(0, 1), $urandom_range(0, 1));
      else if (r < 25) send_req(CmdUnpin, id, $urandom_range(0, 1), $urandom_range(0, 1));
      else if (r < 60 && pinned_q.size() >= n_eff - 1 || r >= 60 && pinned_q.size() > 0
               && r < 80) begin
        // well-formed unpin of a page we pinned earlier
        k = $urandom_range(0, pinned_q.size() - 1);
        send_req(CmdUnpin, pinned_q[k], $urandom_range(0, 1), $urandom_range(0, 1));
        pinned_q.delete(k);
      end else begin
        send_req(CmdPin, id, $urandom_range(0, 1), $urandom_range(0, 1));
        pinned_q.push_back(id);
      end
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    for (int i = 0; i < 24; i++) id_pool[i] = (i < 12) ? i + 1 : $urandom;
    id_pool[22] = 32'hFFFF_FFFF;
    id_pool[23] = 32'h8000_0000;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: hit, miss fills, unpin dirty, underflow, flushes, bad id
    calm = 1'b1;
    send_req(CmdPin, 32'h1, 1, 0);
    send_req(CmdPin, 32'hFFFF_FFFF, 0, 1);
    send_req(CmdPin, 32'h1, 0, 0);
    send_req(CmdUnpin, 32'h1, 0, 1);
    send_req(CmdUnpin, 32'h1, 0, 0);
    send_req(CmdUnpin, 32'h1, 0, 1);             // pin underflow
    send_req(CmdFlush, 32'h1, 0, 0);             // dirty write-back
    send_req(CmdFlush, 32'h1, 0, 0);             // already clean
    send_req(CmdFlush, 32'h1234_5678, 0, 0);     // not resident
    send_req(CmdUnpin, 32'h5555_AAAA, 1, 1);     // not resident
    send_req(CmdPin, 32'h0, 1, 1);               // bad id on pin, unpin and flush
    send_req(CmdUnpin, 32'h0, 0, 0);
    send_req(CmdFlush, 32'h0, 0, 0);
    send_req(CmdUnpin, 32'hFFFF_FFFF, 1, 1);
    send_req(CmdFlushAll, 32'h0, 0, 0);          // one write-back then closing
    send_req(CmdFlushAll, 32'hFFFF_FFFF, 1, 1);  // nothing dirty

    // single slot: usage clearing, clean and dirty eviction, no victim
    set_slots(1);
    send_req(CmdPin, 32'h7, 1, 0);
    send_req(CmdUnpin, 32'h7, 0, 1);
    send_req(CmdPin, 32'h8, 0, 0);
    send_req(CmdPin, 32'h9, 0, 0);               // no victim
    calm = 1'b0;

    // random phases across pool sizes, extremes included
    set_slots(16);
    random_phase(40, 16);
    hold_left = 400;  // receiver goes quiet; the sender keeps offering
    random_phase(30, 16);
    set_slots(5);
    random_phase(20, 5);
    set_slots(0);
    random_phase(15, 1);
    set_slots(31);
    calm = 1'b1;
    random_phase(15, 16);
    calm = 1'b0;
    set_slots(3);
    random_phase(20, 3);
    set_slots(2);
    random_phase(20, 2);

    wait (pending == 0);
    repeat (80) @(posedge clk_i);
    drain = 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);
    $display("covered %0d requests and %0d results over pool sizes 1..16", items_sent,
             results);
    $display("including no-victim sweeps, dirty evictions and a long result stall");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
